// ===== design/dltq_pkg.sv =====
// Shared constants and codes for the delta-list timer queue.
// No dependencies; imported by delta_list_timer_queue.
`timescale 1ns / 1ps
`default_nettype none

package dltq_pkg;

    localparam int CAPACITY   = 16;
    localparam int DELAY_BITS = 16;
    localparam int TASK_BITS  = 8;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // s_tuser codes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // m_tuser codes
    localparam logic KIND_EXPIRED = 1'b0;
    localparam logic KIND_REJECT  = 1'b1;

endpackage

`default_nettype wire

// ===== design/delta_list_timer_queue.sv =====
// Delta-list timer queue: linked table sorted by expiry, walked by one shared
// adder/comparator under a small sequencer. Depends on dltq_pkg.
//
// Insert: into an empty list the entry is written from idle; else the serial
//   walk through the link table, one registered table read per entry, finds
//   the place, then splices the new entry in ahead of it or at the tail.
// Tick: without expiry the head delta is decremented; each expired task goes
//   through the output request handshake. A rejected insert goes there too.
// One request in flight at a time. Reset (aresetn low, synchronous) empties the
// list and frees all slots; table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module delta_list_timer_queue import dltq_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [15:0] delay_ticks, [23:16] task_id
    input  wire logic        s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] task_id_out
    output logic             m_tuser,   // [0] kind
    output logic             m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK_ADDR,
        ST_WALK_CHK,
        ST_FIX,
        ST_TICK_CHK,
        ST_EXP_ADDR,
        ST_EXP_CHK,
        ST_FINAL,
        ST_OUT
    } state_t;

    localparam int SUM_W = DELAY_BITS + 1;

    // link table
    logic [DELAY_BITS-1:0] entry_delta [CAPACITY];
    logic [TASK_BITS-1:0]  entry_task  [CAPACITY];
    logic [IDX_W-1:0]      entry_next  [CAPACITY];

    state_t                state_reg, state_next;
    state_t                ret_reg, ret_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CAPACITY-1:0]   free_reg, free_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      prev_reg, prev_next;
    logic                  have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]      walk_cnt_reg, walk_cnt_next;
    logic [SUM_W-1:0]      total_reg, total_next;
    logic [DELAY_BITS-1:0] delay_reg, delay_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [DELAY_BITS-1:0] fix_delta_reg, fix_delta_next;
    logic [TASK_BITS-1:0]  pend_task_reg, pend_task_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_kind_reg, out_kind_next;
    logic [TASK_BITS-1:0]  out_task_reg, out_task_next;
    logic                  out_last_reg, out_last_next;

    logic [IDX_W-1:0]      rd_addr;
    logic [DELAY_BITS-1:0] rd_delta_reg;
    logic [TASK_BITS-1:0]  rd_task_reg;
    logic [IDX_W-1:0]      rd_next_reg;

    logic                  dw_en, tw_en, nw_en;
    logic [IDX_W-1:0]      dw_addr, tw_addr, nw_addr;
    logic [DELAY_BITS-1:0] dw_data;
    logic [TASK_BITS-1:0]  tw_data;
    logic [IDX_W-1:0]      nw_data;

    logic [IDX_W-1:0]      free_idx;
    logic [DELAY_BITS-1:0] in_delay;
    logic [DELAY_BITS-1:0] delay_eff;
    logic [TASK_BITS-1:0]  in_task;
    logic [SUM_W-1:0]      sum;
    logic [DELAY_BITS-1:0] new_delta;

    assign in_delay  = s_tdata[DELAY_BITS-1:0];
    assign in_task   = s_tdata[DELAY_BITS +: TASK_BITS];
    assign delay_eff = (in_delay == '0) ? DELAY_BITS'(1) : in_delay;

    // shared adder and subtractor of the walk
    assign sum       = total_reg + SUM_W'(rd_delta_reg);
    assign new_delta = delay_reg - total_reg[DELAY_BITS-1:0];

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (free_reg[k]) begin
                free_idx = IDX_W'(k);
            end
        end
    end

    assign rd_addr = (state_reg == ST_WALK_ADDR || state_reg == ST_WALK_CHK) ? cur_reg
                                                                            : head_reg;

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        walk_cnt_next  = walk_cnt_reg;
        total_next     = total_reg;
        delay_next     = delay_reg;
        slot_next      = slot_reg;
        fix_delta_next = fix_delta_reg;
        pend_task_next = pend_task_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_task_next  = out_task_reg;
        out_last_next  = out_last_reg;
        dw_en   = 1'b0;
        dw_addr = slot_reg;
        dw_data = new_delta;
        tw_en   = 1'b0;
        tw_addr = free_idx;
        tw_data = in_task;
        nw_en   = 1'b0;
        nw_addr = slot_reg;
        nw_data = cur_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == OP_INSERT) begin
                        if (count_reg == CNT_W'(CAPACITY)) begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_REJECT;
                            out_task_next  = in_task;
                            out_last_next  = 1'b1;
                            ret_next       = ST_IDLE;
                            state_next     = ST_OUT;
                        end else begin
                            free_next[free_idx] = 1'b0;
                            tw_en          = 1'b1;
                            slot_next      = free_idx;
                            delay_next     = delay_eff;
                            if (count_reg == '0) begin
                                dw_en      = 1'b1;
                                dw_addr    = free_idx;
                                dw_data    = delay_eff;
                                head_next  = free_idx;
                                count_next = CNT_W'(1);
                            end else begin
                                cur_next       = head_reg;
                                have_prev_next = 1'b0;
                                walk_cnt_next  = '0;
                                total_next     = '0;
                                // head entry is read on this edge
                                state_next     = ST_WALK_CHK;
                            end
                        end
                    end else if (count_reg != '0) begin
                        state_next = ST_TICK_CHK;
                    end
                end
            end
            ST_WALK_ADDR: begin
                state_next = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                if (sum >= SUM_W'(delay_reg)) begin
                    // new entry goes ahead of cur
                    dw_en   = 1'b1;
                    dw_addr = slot_reg;
                    dw_data = new_delta;
                    nw_en   = 1'b1;
                    nw_addr = slot_reg;
                    nw_data = cur_reg;
                    if (!have_prev_reg) begin
                        head_next = slot_reg;
                    end
                    fix_delta_next = rd_delta_reg - new_delta;
                    state_next     = ST_FIX;
                end else if (walk_cnt_reg == count_reg - CNT_W'(1)) begin
                    // append behind the tail
                    dw_en      = 1'b1;
                    dw_addr    = slot_reg;
                    dw_data    = delay_reg - sum[DELAY_BITS-1:0];
                    nw_en      = 1'b1;
                    nw_addr    = cur_reg;
                    nw_data    = slot_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end else begin
                    prev_next      = cur_reg;
                    have_prev_next = 1'b1;
                    cur_next       = rd_next_reg;
                    total_next     = sum;
                    walk_cnt_next  = walk_cnt_reg + CNT_W'(1);
                    state_next     = ST_WALK_ADDR;
                end
            end
            ST_FIX: begin
                dw_en   = 1'b1;
                dw_addr = cur_reg;
                dw_data = fix_delta_reg;
                if (have_prev_reg) begin
                    nw_en   = 1'b1;
                    nw_addr = prev_reg;
                    nw_data = slot_reg;
                end
                count_next = count_reg + CNT_W'(1);
                state_next = ST_IDLE;
            end
            ST_TICK_CHK: begin
                if (rd_delta_reg > DELAY_BITS'(1)) begin
                    dw_en      = 1'b1;
                    dw_addr    = head_reg;
                    dw_data    = rd_delta_reg - DELAY_BITS'(1);
                    state_next = ST_IDLE;
                end else begin
                    free_next[head_reg] = 1'b1;
                    head_next  = rd_next_reg;
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1)) begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_EXPIRED;
                        out_task_next  = rd_task_reg;
                        out_last_next  = 1'b1;
                        ret_next       = ST_IDLE;
                        state_next     = ST_OUT;
                    end else begin
                        pend_task_next = rd_task_reg;
                        state_next     = ST_EXP_ADDR;
                    end
                end
            end
            ST_EXP_ADDR: begin
                state_next = ST_EXP_CHK;
            end
            ST_EXP_CHK: begin
                // pending task is last unless the new head also expires
                out_valid_next = 1'b1;
                out_kind_next  = KIND_EXPIRED;
                out_task_next  = pend_task_reg;
                state_next     = ST_OUT;
                if (rd_delta_reg != '0) begin
                    out_last_next = 1'b1;
                    ret_next      = ST_IDLE;
                end else begin
                    out_last_next       = 1'b0;
                    pend_task_next      = rd_task_reg;
                    free_next[head_reg] = 1'b1;
                    head_next           = rd_next_reg;
                    count_next          = count_reg - CNT_W'(1);
                    ret_next = (count_reg == CNT_W'(1)) ? ST_FINAL : ST_EXP_ADDR;
                end
            end
            ST_FINAL: begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_EXPIRED;
                out_task_next  = pend_task_reg;
                out_last_next  = 1'b1;
                ret_next       = ST_IDLE;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    state_next     = ret_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            free_reg      <= '1;
            have_prev_reg <= 1'b0;
            walk_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            have_prev_reg <= have_prev_next;
            walk_cnt_reg  <= walk_cnt_next;
            out_valid_reg <= out_valid_next;
        end
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        total_reg     <= total_next;
        delay_reg     <= delay_next;
        slot_reg      <= slot_next;
        fix_delta_reg <= fix_delta_next;
        pend_task_reg <= pend_task_next;
        out_kind_reg  <= out_kind_next;
        out_task_reg  <= out_task_next;
        out_last_reg  <= out_last_next;
    end

    // link table: one write port per field, registered read
    always_ff @(posedge aclk) begin
        if (dw_en) begin
            entry_delta[dw_addr] <= dw_data;
        end
        if (tw_en) begin
            entry_task[tw_addr] <= tw_data;
        end
        if (nw_en) begin
            entry_next[nw_addr] <= nw_data;
        end
        rd_delta_reg <= entry_delta[rd_addr];
        rd_task_reg  <= entry_task[rd_addr];
        rd_next_reg  <= entry_next[rd_addr];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_task_reg;
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("pending count above capacity");

    a_free_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> ($countones(free_reg) + count_reg) == CAPACITY)
        else $error("free flags disagree with pending count");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_REJECT |-> m_tlast)
        else $error("reject result not marked last");

    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE && s_tvalid && s_tuser == OP_INSERT
            && count_reg != CNT_W'(CAPACITY) |=> !m_tvalid)
        else $error("insert into non-full table produced a result");

endmodule

`default_nettype wire

// ===== verif/delta_list_timer_queue_tb.sv =====
// Self-checking bench for delta_list_timer_queue: directed table, random phases
// with idle/stall mixes and an output hold-off, checked by a delta-list predictor.
// Depends on dltq_pkg and the delta_list_timer_queue RTL.
`timescale 1ns / 1ps

module delta_list_timer_queue_tb;
    import dltq_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
    // slowest request: full walk or 16 expirations, each behind a long stall,
    // plus the forced hold-off; taken several times over
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 33;

    typedef struct packed {
        logic                 kind;
        logic [TASK_BITS-1:0] tid;
        logic                 last;
    } release_t;

    typedef struct {
        logic                  op;
        logic [DELAY_BITS-1:0] dly;
        logic [TASK_BITS-1:0]  tid;
        bit                    typed;      // expected result typed in below
        bit                    typed_any;  // typed row produces one result
        release_t              typed_res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // [15:0] delay_ticks, [23:16] task_id
    logic        s_tuser = 1'b0;  // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] task_id_out
    logic        m_tuser;         // [0] kind
    logic        m_tlast;

    always #10 aclk = ~aclk;

    delta_list_timer_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // predictor copy of the timer table
    logic [DELAY_BITS-1:0] tbl_delta [CAPACITY];
    logic [TASK_BITS-1:0]  tbl_tid   [CAPACITY];
    logic [IDX_W-1:0]      tbl_link  [CAPACITY];
    bit                    tbl_free  [CAPACITY];
    logic [IDX_W-1:0]      tbl_head;
    int                    tbl_count;

    release_t fresh_q[$];    // results of the request just predicted
    release_t release_q[$];  // expiries and rejections still owed by the block

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_start = 1'b0;
    int hold_left = 0;
    int mismatches = 0;
    int n_requests = 0;
    int n_expired = 0;
    int n_rejected = 0;
    int quiet_cycles = 0;

    int tx_pcts [4] = '{0, 83, 0, 6};
    int rx_pcts [4] = '{0, 0, 83, 6};

    function automatic void timer_table_clear();
        for (int i = 0; i < CAPACITY; i++) begin
            tbl_delta[i] = '0;
            tbl_tid[i]   = '0;
            tbl_link[i]  = '0;
            tbl_free[i]  = 1'b1;
        end
        tbl_head  = '0;
        tbl_count = 0;
    endfunction

    function automatic void timer_table_insert(input logic [DELAY_BITS-1:0] dly_in,
                                               input logic [TASK_BITS-1:0] tid);
        logic [DELAY_BITS-1:0] dly;
        logic [IDX_W-1:0] slot, cur, prev;
        int i;
        bit have_prev, found;
        int unsigned sum, sum_before;
        release_t r;
        dly = (dly_in == '0) ? DELAY_BITS'(1) : dly_in;
        if (tbl_count >= CAPACITY) begin
            r.kind = KIND_REJECT;
            r.tid  = tid;
            r.last = 1'b1;
            fresh_q.push_back(r);
            return;
        end
        slot = '0;
        for (i = CAPACITY - 1; i >= 0; i--)
            if (tbl_free[i]) slot = IDX_W'(i);
        tbl_free[slot] = 1'b0;
        tbl_tid[slot]  = tid;
        tbl_link[slot] = '0;
        if (tbl_count == 0) begin
            tbl_delta[slot] = dly;
            tbl_head = slot;
            tbl_count = 1;
            return;
        end
        cur = tbl_head;
        prev = '0;
        have_prev = 1'b0;
        found = 1'b0;
        sum = 0;
        sum_before = 0;
        for (i = 0; i < tbl_count; i++) begin
            sum_before = sum;
            sum += 32'(tbl_delta[cur]);
            if (sum >= 32'(dly)) begin
                found = 1'b1;
                break;
            end
            prev = cur;
            have_prev = 1'b1;
            cur = tbl_link[cur];
        end
        if (!found) begin
            tbl_delta[slot] = DELAY_BITS'(32'(dly) - sum);
            tbl_link[prev] = slot;
        end else begin
            // new entry goes ahead of anything due at the same tick
            tbl_delta[slot] = DELAY_BITS'(32'(dly) - sum_before);
            tbl_delta[cur]  = tbl_delta[cur] - tbl_delta[slot];
            tbl_link[slot]  = cur;
            if (have_prev) tbl_link[prev] = slot;
            else tbl_head = slot;
        end
        tbl_count++;
    endfunction

    function automatic void timer_table_tick();
        logic [IDX_W-1:0] h;
        int n;
        release_t r;
        if (tbl_count == 0) return;
        h = tbl_head;
        if (tbl_delta[h] > DELAY_BITS'(1)) begin
            tbl_delta[h]--;
            return;
        end
        tbl_delta[h] = '0;
        n = 0;
        while (tbl_count > 0 && n < CAPACITY) begin
            h = tbl_head;
            if (tbl_delta[h] != '0) break;
            r.kind = KIND_EXPIRED;
            r.tid  = tbl_tid[h];
            r.last = 1'b0;
            fresh_q.push_back(r);
            n++;
            tbl_free[h] = 1'b1;
            tbl_head = tbl_link[h];
            tbl_count--;
        end
        if (n > 0) begin
            r = fresh_q.pop_back();
            r.last = 1'b1;
            fresh_q.push_back(r);
        end
    endfunction

    function automatic void timer_table_step(input logic op, input logic [DELAY_BITS-1:0] dly,
                                             input logic [TASK_BITS-1:0] tid);
        fresh_q.delete();
        if (op == OP_INSERT) timer_table_insert(dly, tid);
        else timer_table_tick();
    endfunction

    function automatic stim_row_t plain_row(input logic op, input int dly, input int tid);
        stim_row_t row;
        row.op = op;
        row.dly = DELAY_BITS'(dly);
        row.tid = TASK_BITS'(tid);
        row.typed = 1'b0;
        row.typed_any = 1'b0;
        row.typed_res = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic op, input int dly, input int tid,
                                            input bit any, input logic kind, input int rtid);
        stim_row_t row;
        row = plain_row(op, dly, tid);
        row.typed = 1'b1;
        row.typed_any = any;
        row.typed_res.kind = kind;
        row.typed_res.tid = TASK_BITS'(rtid);
        row.typed_res.last = 1'b1;
        return row;
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t row;
        int pick;
        row = plain_row(OP_TICK, $urandom_range(0, 65535), $urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick >= 45) begin
            row.op = OP_INSERT;
            // mostly short delays so timers keep expiring; rarely the full range
            if (pick < 80) row.dly = DELAY_BITS'($urandom_range(0, 6));
            else if (pick < 97) row.dly = DELAY_BITS'($urandom_range(7, 40));
        end
        return row;
    endfunction

    task automatic send_request(input stim_row_t row);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row.tid, row.dly};
        s_tuser  <= row.op;
        do @(posedge aclk); while (!s_tready);
        timer_table_step(row.op, row.dly, row.tid);
        if (row.typed) begin
            if (row.typed_any) release_q.push_back(row.typed_res);
        end else begin
            foreach (fresh_q[k]) release_q.push_back(fresh_q[k]);
        end
        n_requests++;
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (release_q.size() != 0) @(posedge aclk);
        // a successful insert leaves no result but may still be walking the list
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("MISMATCH at %0t: %s got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // result side: check, then pick tready for the next cycle
    always @(posedge aclk) begin
        release_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (release_q.size() == 0) begin
                    report_mismatch("unexpected result, task id", m_tdata, 0);
                end else begin
                    want = release_q.pop_front();
                    if (m_tuser !== want.kind) report_mismatch("kind", m_tuser, want.kind);
                    if (m_tdata !== want.tid) report_mismatch("task id", m_tdata, want.tid);
                    if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
                    if (want.kind == KIND_REJECT) n_rejected++;
                    else n_expired++;
                end
            end
            if (hold_start) begin
                hold_left = HOLD_CYCLES;
                hold_start = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t directed[$];
        stim_row_t row;
        timer_table_clear();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // tick on an empty list is ignored
        directed.push_back(typed_row(OP_TICK, 16'hFFFF, 8'hFF, 1'b0, KIND_EXPIRED, 0));
        // zero delay behaves as one tick
        directed.push_back(typed_row(OP_INSERT, 0, 8'hAA, 1'b0, KIND_EXPIRED, 0));
        directed.push_back(typed_row(OP_TICK, 0, 0, 1'b1, KIND_EXPIRED, 8'hAA));
        // equal expiry: second insert goes first, both leave on one tick
        directed.push_back(plain_row(OP_INSERT, 2, 8'h01));
        directed.push_back(plain_row(OP_INSERT, 2, 8'h02));
        directed.push_back(plain_row(OP_TICK, 0, 0));
        directed.push_back(plain_row(OP_TICK, 0, 0));
        // fill the table, reject one more, then release all sixteen at once
        for (int i = 0; i < CAPACITY; i++)
            directed.push_back(plain_row(OP_INSERT, 1, (i == 0) ? 8'hFF : 8'h10 + i));
        directed.push_back(typed_row(OP_INSERT, 16'hFFFF, 8'h00, 1'b1, KIND_REJECT, 8'h00));
        directed.push_back(plain_row(OP_TICK, 0, 0));
        foreach (directed[i]) send_request(directed[i]);
        pause_until_drained();

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct = tx_pcts[ph];
            rx_stall_pct = rx_pcts[ph];
            repeat (RANDOM_ITEMS) send_request(random_row());
            pause_until_drained();
        end
        tx_idle_pct = 0;
        rx_stall_pct = 0;

        // output held off while requests keep coming: the block backs up
        hold_start = 1'b1;
        for (int i = 0; i < 24; i++) begin
            if (i % 2 == 0) row = plain_row(OP_INSERT, $urandom_range(1, 2), $urandom_range(0, 255));
            else row = plain_row(OP_TICK, $urandom_range(0, 65535), $urandom_range(0, 255));
            send_request(row);
        end
        pause_until_drained();

        $display("Covered %0d requests: empty ticks, zero delay, equal expiry, full table,",
                 n_requests);
        $display("  %0d expirations and %0d rejections under idle, stall and hold-off mixes",
                 n_expired, n_rejected);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
